// ===== hw/rtl/txr_pkg.sv =====
// Shared types, constants and helper functions for the torus XY route path block.
// Used by txr_ctrl, txr_datapath and torus_xy_route_path_core; depends on nothing.

package txr_pkg;

    localparam int MAX_DIM    = 16;
    localparam int NODE_W     = 8;
    localparam int CFG_W      = 5;
    localparam int GRID_RESET = 4;
    // a dimension value 1..MAX_DIM
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    // a row or column coordinate 0..MAX_DIM-1
    localparam int COORD_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    // node count rows*cols, wide enough to compare against any 8-bit node number
    localparam int TOTAL_W    = (2 * CNT_W > NODE_W + 1) ? 2 * CNT_W : NODE_W + 1;
    localparam int DIV_CNT_W  = $clog2(NODE_W);

    typedef enum logic [0:0] {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SETUP,
        ST_EMIT_SRC,
        ST_COL_MOVE,
        ST_ROW_MOVE,
        ST_ERROR
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_ROUTE,
        CMD_EMIT_SRC,
        CMD_STEP_COL,
        CMD_STEP_ROW,
        CMD_EMIT_BAD
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic div_done;
        logic col_zero;
        logic row_zero;
        logic col_one;
        logic row_one;
        logic out_free;
    } status_t;

    // zero reads as one, oversized values clamp to MAX_DIM
    function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        int w;
        w = int'(v);
        if (w == 0)
        begin
            w = 1;
        end
        else if (w > MAX_DIM)
        begin
            w = MAX_DIM;
        end
        return CNT_W'(w);
    endfunction

endpackage

// ===== hw/rtl/txr_ctrl.sv =====
// Controller state machine for the torus XY route path block.
// Depends on txr_pkg; drives commands into txr_datapath and reads its status.

module txr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  txr_pkg::status_t  status,
    output txr_pkg::cmd_t     cmd
);

    txr_pkg::state_t state_reg;
    txr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= txr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            txr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = txr_pkg::ST_CHECK;
                end
            end
            txr_pkg::ST_CHECK:
            begin
                state_next = status.bad ? txr_pkg::ST_ERROR : txr_pkg::ST_DIVIDE;
            end
            txr_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = txr_pkg::ST_SETUP;
                end
            end
            txr_pkg::ST_SETUP:
            begin
                state_next = txr_pkg::ST_EMIT_SRC;
            end
            txr_pkg::ST_EMIT_SRC:
            begin
                if (status.out_free)
                begin
                    if (!status.col_zero)
                    begin
                        state_next = txr_pkg::ST_COL_MOVE;
                    end
                    else if (!status.row_zero)
                    begin
                        state_next = txr_pkg::ST_ROW_MOVE;
                    end
                    else
                    begin
                        state_next = txr_pkg::ST_IDLE;
                    end
                end
            end
            txr_pkg::ST_COL_MOVE:
            begin
                if (status.out_free && status.col_one)
                begin
                    state_next = status.row_zero ? txr_pkg::ST_IDLE : txr_pkg::ST_ROW_MOVE;
                end
            end
            txr_pkg::ST_ROW_MOVE:
            begin
                if (status.out_free && status.row_one)
                begin
                    state_next = txr_pkg::ST_IDLE;
                end
            end
            txr_pkg::ST_ERROR:
            begin
                if (status.out_free)
                begin
                    state_next = txr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = txr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = txr_pkg::CMD_NONE;
        case (state_reg)
            txr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd      = s_tvalid ? txr_pkg::CMD_LOAD : txr_pkg::CMD_NONE;
            end
            txr_pkg::ST_CHECK:
            begin
                cmd = status.bad ? txr_pkg::CMD_NONE : txr_pkg::CMD_DIV_START;
            end
            txr_pkg::ST_DIVIDE:
            begin
                cmd = txr_pkg::CMD_DIV_STEP;
            end
            txr_pkg::ST_SETUP:
            begin
                cmd = txr_pkg::CMD_ROUTE;
            end
            txr_pkg::ST_EMIT_SRC:
            begin
                cmd = status.out_free ? txr_pkg::CMD_EMIT_SRC : txr_pkg::CMD_NONE;
            end
            txr_pkg::ST_COL_MOVE:
            begin
                cmd = status.out_free ? txr_pkg::CMD_STEP_COL : txr_pkg::CMD_NONE;
            end
            txr_pkg::ST_ROW_MOVE:
            begin
                cmd = status.out_free ? txr_pkg::CMD_STEP_ROW : txr_pkg::CMD_NONE;
            end
            txr_pkg::ST_ERROR:
            begin
                cmd = status.out_free ? txr_pkg::CMD_EMIT_BAD : txr_pkg::CMD_NONE;
            end
            default:
            begin
                cmd = txr_pkg::CMD_NONE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/txr_datapath.sv =====
// Datapath of the torus XY route path block: operand registers, shift-subtract
// divider, ring distance logic, position stepping and the output register.
// Depends on txr_pkg; controlled by txr_ctrl through cmd and status.

module txr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  txr_pkg::cmd_t                 cmd,
    output txr_pkg::status_t              status,
    input  logic [txr_pkg::NODE_W-1:0]    src_in,
    input  logic [txr_pkg::NODE_W-1:0]    dst_in,
    input  logic [txr_pkg::CNT_W-1:0]     rows,
    input  logic [txr_pkg::CNT_W-1:0]     cols,
    input  logic [txr_pkg::TOTAL_W-1:0]   total,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [txr_pkg::NODE_W-1:0]    path_node,
    output logic                          last_hop,
    output logic                          bad_node
);

    localparam int NW = txr_pkg::NODE_W;
    localparam int CW = txr_pkg::CNT_W;
    localparam int PW = txr_pkg::COORD_W;
    localparam int TW = txr_pkg::TOTAL_W;
    localparam int DW = txr_pkg::DIV_CNT_W;

    logic [NW-1:0] src_reg;
    logic [NW-1:0] dst_reg;
    logic [NW-1:0] qs_reg;
    logic [NW-1:0] qd_reg;
    logic [CW-1:0] rs_reg;
    logic [CW-1:0] rd_reg;
    logic [DW-1:0] div_cnt_reg;
    logic [PW-1:0] cur_row_reg;
    logic [PW-1:0] cur_col_reg;
    logic [PW-1:0] col_steps_reg;
    logic [PW-1:0] row_steps_reg;
    logic          col_neg_reg;
    logic          row_neg_reg;
    logic          out_valid_reg;
    logic [NW-1:0] out_node_reg;
    logic          out_last_reg;
    logic          out_bad_reg;

    logic [CW:0]   rs_sh;
    logic [CW:0]   rd_sh;
    logic          rs_fit;
    logic          rd_fit;
    logic [CW:0]   rs_new;
    logic [CW:0]   rd_new;
    logic [PW:0]   col_route;
    logic [PW:0]   row_route;
    logic [PW-1:0] col_nxt;
    logic [PW-1:0] row_nxt;
    logic [PW-1:0] row_x;
    logic [PW-1:0] col_x;
    logic [TW-1:0] node_full;
    logic          out_free;

    // {neg, steps}: shorter way from a to b on a ring of n, ties go positive
    function automatic logic [PW:0] ring_route(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b,
                                               input logic [CW-1:0] n);
        logic [CW:0] ae;
        logic [CW:0] be;
        logic [CW:0] ne;
        logic [CW:0] fwd;
        logic [CW:0] bwd;
        ae  = (CW+1)'(a);
        be  = (CW+1)'(b);
        ne  = (CW+1)'(n);
        fwd = (be >= ae) ? (be - ae) : (be + ne - ae);
        bwd = (ae >= be) ? (ae - be) : (ae + ne - be);
        if (fwd <= bwd)
        begin
            return {1'b0, fwd[PW-1:0]};
        end
        return {1'b1, bwd[PW-1:0]};
    endfunction

    // one restoring divide step per cycle, both operands in parallel
    always_comb
    begin
        rs_sh  = {rs_reg, qs_reg[NW-1]};
        rd_sh  = {rd_reg, qd_reg[NW-1]};
        rs_fit = rs_sh >= {1'b0, cols};
        rd_fit = rd_sh >= {1'b0, cols};
        rs_new = rs_fit ? (rs_sh - {1'b0, cols}) : rs_sh;
        rd_new = rd_fit ? (rd_sh - {1'b0, cols}) : rd_sh;
    end

    assign col_route = ring_route(rs_reg[PW-1:0], rd_reg[PW-1:0], cols);
    assign row_route = ring_route(qs_reg[PW-1:0], qd_reg[PW-1:0], rows);

    always_comb
    begin
        if (col_neg_reg)
        begin
            col_nxt = (cur_col_reg == '0) ? PW'(cols - 1'b1) : (cur_col_reg - 1'b1);
        end
        else
        begin
            col_nxt = ((CW+1)'(cur_col_reg) + 1'b1 >= (CW+1)'(cols)) ? '0
                      : (cur_col_reg + 1'b1);
        end
        if (row_neg_reg)
        begin
            row_nxt = (cur_row_reg == '0) ? PW'(rows - 1'b1) : (cur_row_reg - 1'b1);
        end
        else
        begin
            row_nxt = ((CW+1)'(cur_row_reg) + 1'b1 >= (CW+1)'(rows)) ? '0
                      : (cur_row_reg + 1'b1);
        end
        row_x     = (cmd == txr_pkg::CMD_STEP_ROW) ? row_nxt : cur_row_reg;
        col_x     = (cmd == txr_pkg::CMD_STEP_COL) ? col_nxt : cur_col_reg;
        node_full = TW'(row_x) * TW'(cols) + TW'(col_x);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        status.bad      = (TW'(src_reg) >= total) || (TW'(dst_reg) >= total);
        status.div_done = div_cnt_reg == DW'(NW - 1);
        status.col_zero = col_steps_reg == '0;
        status.row_zero = row_steps_reg == '0;
        status.col_one  = col_steps_reg == PW'(1);
        status.row_one  = row_steps_reg == PW'(1);
        status.out_free = out_free;
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            txr_pkg::CMD_LOAD:
            begin
                src_reg <= src_in;
                dst_reg <= dst_in;
            end
            txr_pkg::CMD_DIV_START:
            begin
                qs_reg      <= src_reg;
                qd_reg      <= dst_reg;
                rs_reg      <= '0;
                rd_reg      <= '0;
                div_cnt_reg <= '0;
            end
            txr_pkg::CMD_DIV_STEP:
            begin
                qs_reg      <= {qs_reg[NW-2:0], rs_fit};
                qd_reg      <= {qd_reg[NW-2:0], rd_fit};
                rs_reg      <= rs_new[CW-1:0];
                rd_reg      <= rd_new[CW-1:0];
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            txr_pkg::CMD_ROUTE:
            begin
                cur_row_reg   <= qs_reg[PW-1:0];
                cur_col_reg   <= rs_reg[PW-1:0];
                col_steps_reg <= col_route[PW-1:0];
                col_neg_reg   <= col_route[PW];
                row_steps_reg <= row_route[PW-1:0];
                row_neg_reg   <= row_route[PW];
            end
            txr_pkg::CMD_STEP_COL:
            begin
                cur_col_reg   <= col_nxt;
                col_steps_reg <= col_steps_reg - 1'b1;
            end
            txr_pkg::CMD_STEP_ROW:
            begin
                cur_row_reg   <= row_nxt;
                row_steps_reg <= row_steps_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd == txr_pkg::CMD_EMIT_SRC || cmd == txr_pkg::CMD_STEP_COL ||
                 cmd == txr_pkg::CMD_STEP_ROW || cmd == txr_pkg::CMD_EMIT_BAD)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            txr_pkg::CMD_EMIT_SRC:
            begin
                out_node_reg <= src_reg;
                out_last_reg <= status.col_zero && status.row_zero;
                out_bad_reg  <= 1'b0;
            end
            txr_pkg::CMD_STEP_COL:
            begin
                out_node_reg <= node_full[NW-1:0];
                out_last_reg <= status.col_one && status.row_zero;
                out_bad_reg  <= 1'b0;
            end
            txr_pkg::CMD_STEP_ROW:
            begin
                out_node_reg <= node_full[NW-1:0];
                out_last_reg <= status.row_one;
                out_bad_reg  <= 1'b0;
            end
            txr_pkg::CMD_EMIT_BAD:
            begin
                out_node_reg <= '0;
                out_last_reg <= 1'b1;
                out_bad_reg  <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign path_node = out_node_reg;
    assign last_hop  = out_last_reg;
    assign bad_node  = out_bad_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == txr_pkg::CMD_EMIT_SRC || cmd == txr_pkg::CMD_STEP_COL ||
         cmd == txr_pkg::CMD_STEP_ROW || cmd == txr_pkg::CMD_EMIT_BAD)
        |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while stalled");

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_bad_reg) |-> out_last_reg)
        else $error("error result not marked last");

    a_col_step_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == txr_pkg::CMD_STEP_COL) |-> (col_steps_reg != '0))
        else $error("column step with no steps left");

    a_row_step_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == txr_pkg::CMD_STEP_ROW) |-> (col_steps_reg == '0 && row_steps_reg != '0))
        else $error("row step out of order");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == txr_pkg::CMD_ROUTE) |-> (rs_reg < cols && rd_reg < cols))
        else $error("divider remainder not below column count");

endmodule

// ===== hw/rtl/torus_xy_route_path_core.sv =====
// Top level of the torus XY route path block: stream ports, grid registers
// and node count. Depends on txr_pkg, txr_ctrl and txr_datapath.

// Takes a source and destination node of a rows-by-cols torus (row-major numbering,
// grid_rows and grid_cols set through the cfg port, 4x4 after reset) and streams the
// dimension-order path: source first, then column hops, then row hops, each along the
// shorter wrap direction with ties going positive; m_tlast marks the final node. A
// node outside the grid yields a single transaction with m_tuser set and node 0. A
// request first passes through the one-bit-per-cycle divider that splits both nodes into
// row and column; the path then leaves at one node per cycle while m_tready is high. A
// new request is taken while the last node of the previous path still waits in the
// output register. Write the grid registers only while no request is in progress.

module torus_xy_route_path_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*txr_pkg::NODE_W-1:0]    s_tdata,   // [7:0] source_node, [15:8] dest_node
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [txr_pkg::NODE_W-1:0]      m_tdata,   // [7:0] path_node
    output logic                            m_tlast,
    output logic [0:0]                      m_tuser,   // [0] bad_node
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_index,
    input  logic [txr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CW = txr_pkg::CNT_W;
    localparam int TW = txr_pkg::TOTAL_W;
    localparam int NW = txr_pkg::NODE_W;

    logic [txr_pkg::CFG_W-1:0] grid_rows_reg;
    logic [txr_pkg::CFG_W-1:0] grid_cols_reg;
    logic [TW-1:0]             total_reg;
    logic [CW-1:0]             rows_eff;
    logic [CW-1:0]             cols_eff;
    txr_pkg::cmd_t             cmd;
    txr_pkg::status_t          status;
    logic                      bad_flag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= txr_pkg::CFG_W'(txr_pkg::GRID_RESET);
            grid_cols_reg <= txr_pkg::CFG_W'(txr_pkg::GRID_RESET);
        end
        else if (cfg_valid)
        begin
            case (txr_pkg::cfg_reg_t'(cfg_index))
                txr_pkg::REG_GRID_ROWS:
                begin
                    grid_rows_reg <= cfg_data;
                end
                txr_pkg::REG_GRID_COLS:
                begin
                    grid_cols_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rows_eff = txr_pkg::eff_dim(grid_rows_reg);
    assign cols_eff = txr_pkg::eff_dim(grid_cols_reg);

    // node count is registered from the effective grid dimensions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TW'(txr_pkg::GRID_RESET * txr_pkg::GRID_RESET);
        end
        else
        begin
            total_reg <= TW'(rows_eff) * TW'(cols_eff);
        end
    end

    txr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    txr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .src_in    (s_tdata[NW-1:0]),
        .dst_in    (s_tdata[2*NW-1:NW]),
        .rows      (rows_eff),
        .cols      (cols_eff),
        .total     (total_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .path_node (m_tdata),
        .last_hop  (m_tlast),
        .bad_node  (bad_flag)
    );

    assign m_tuser = bad_flag;

endmodule
